/* rtl/module_response_line_tracker_core_assert.svh */
// Assertion helpers for the response line tracker.
// Both expect clk and rst_n in scope.
`ifndef MODULE_RESPONSE_LINE_TRACKER_CORE_ASSERT_SVH
`define MODULE_RESPONSE_LINE_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication
`define MRLT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication
`define MRLT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* rtl/mrlt_pkg.sv */
package mrlt_pkg;

  localparam int LINE_MAX  = 48;
  localparam int LEN_W     = 6;
  localparam int CHAR_W    = 8;
  localparam int TIMEOUT_W = 20;
  localparam int CONN_W    = 8;

  localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX = {TIMEOUT_W{1'b1}};
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd30000;
  localparam logic [CONN_W-1:0]    CONN_MAX    = 8'hFF;
  localparam logic [LEN_W-1:0]     LEN_LIMIT   = LEN_W'(LINE_MAX);
  localparam logic [LEN_W-1:0]     CODE_LEN    = 6'd3;

  // Characters of interest
  localparam logic [CHAR_W-1:0] CH_A  = 8'd65;
  localparam logic [CHAR_W-1:0] CH_Z  = 8'd90;
  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_O  = 8'h4F;
  localparam logic [CHAR_W-1:0] CH_N  = 8'h4E;
  localparam logic [CHAR_W-1:0] CH_K  = 8'h4B;
  localparam logic [CHAR_W-1:0] CH_I  = 8'h49;
  localparam logic [CHAR_W-1:0] CH_M  = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_B  = 8'h42;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_ACK     = 3'd0,
    EV_CONN    = 3'd1,
    EV_DISC    = 3'd2,
    EV_PLAY    = 3'd3,
    EV_STOP    = 3'd4,
    EV_UNKNOWN = 3'd5,
    EV_PAIR    = 3'd6
  } ev_kind_t;

  typedef struct packed {
    op_t               opcode;
    logic [CHAR_W-1:0] rx_byte;
    logic              stop_bit;
  } item_t;

  // Line completion from the assembler to the status logic
  typedef struct packed {
    logic     done;
    ev_kind_t kind;
  } line_evt_t;

  typedef struct packed {
    logic              valid;
    ev_kind_t          kind;
    logic              ok;
    logic [CONN_W-1:0] conn;
    logic              play;
    logic              pair;
  } result_t;

endpackage

/* rtl/mrlt_chan_if.sv */
// Request channels of the tracker

interface mrlt_in_if;
  import mrlt_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [CHAR_W-1:0] rx_byte;
  logic              stop_bit;
  modport source (output valid, opcode, rx_byte, stop_bit, input ready);
  modport sink   (input valid, opcode, rx_byte, stop_bit, output ready);
endinterface

interface mrlt_out_if;
  import mrlt_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        event_kind;
  logic              ok_seen;
  logic [CONN_W-1:0] connection_count;
  logic              playback_active;
  logic              pairing_active;
  modport source (output valid, event_kind, ok_seen, connection_count,
                  playback_active, pairing_active, input ready);
  modport sink   (input valid, event_kind, ok_seen, connection_count,
                  playback_active, pairing_active, output ready);
endinterface

interface mrlt_cfg_if;
  import mrlt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TIMEOUT_W-1:0] autopair_timeout_ms;
  modport source (output valid, autopair_timeout_ms, input ready);
  modport sink   (input valid, autopair_timeout_ms, output ready);
endinterface

/* rtl/mrlt_line.sv */
module mrlt_line
  import mrlt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  item_t     item,
  input  logic      step,
  output line_evt_t evt
);

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CHAR_W-1:0] first_r, first_nxt;
  logic [CHAR_W-1:0] second_r, second_nxt;
  logic              cr_r, cr_nxt;
  logic              await_r, await_nxt;

  logic is_upper, start_bad, take, ends, is_code;

  assign is_upper  = (item.rx_byte >= CH_A) && (item.rx_byte <= CH_Z);
  assign start_bad = (await_r || (len_r == '0)) && !is_upper;
  assign take      = item_valid && (item.opcode == OP_BYTE) && item.stop_bit
                     && !start_bad && (len_r < LEN_LIMIT);
  assign ends      = take && (item.rx_byte == CH_LF) && cr_r && (len_r != '0);
  // two-letter code plus the CR
  assign is_code   = (len_r == CODE_LEN);

  // Classify the line that the LF closes
  always_comb begin
    evt.done = ends;
    evt.kind = EV_UNKNOWN;
    if (is_code) begin
      if (first_r == CH_O && (second_r == CH_N || second_r == CH_K)) begin
        evt.kind = EV_ACK;
      end else if (first_r == CH_I && second_r == CH_I) begin
        evt.kind = EV_CONN;
      end else if (first_r == CH_I && second_r == CH_A) begin
        evt.kind = EV_DISC;
      end else if (first_r == CH_M && second_r == CH_B) begin
        evt.kind = EV_PLAY;
      end else if (first_r == CH_M && second_r == CH_A) begin
        evt.kind = EV_STOP;
      end
    end
  end

  // Line assembly
  always_comb begin
    len_nxt    = len_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    cr_nxt     = cr_r;
    await_nxt  = await_r;
    if (take) begin
      if (ends) begin
        len_nxt   = '0;
        cr_nxt    = 1'b0;
        await_nxt = 1'b1;
      end else begin
        await_nxt = 1'b0;
        if (len_r == '0) begin
          first_nxt = item.rx_byte;
        end else if (len_r == LEN_W'(1)) begin
          second_nxt = item.rx_byte;
        end
        cr_nxt  = (item.rx_byte == CH_CR);
        len_nxt = len_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
      cr_r     <= 1'b0;
      await_r  <= 1'b0;
    end else if (step) begin
      len_r    <= len_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      cr_r     <= cr_nxt;
      await_r  <= await_nxt;
    end
  end

endmodule

/* rtl/mrlt_stat.sv */
`include "module_response_line_tracker_core_assert.svh"

module mrlt_stat
  import mrlt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  item_t                item,
  input  line_evt_t            evt,
  input  logic                 step,
  input  logic                 cfg_we,
  input  logic [TIMEOUT_W-1:0] cfg_data,
  output result_t              res
);

  logic [TIMEOUT_W-1:0] timeout_r;
  logic [CONN_W-1:0]    conn_r, conn_nxt, conn_dec;
  logic                 play_r, play_nxt;
  logic                 pair_r, pair_nxt;
  logic [TIMEOUT_W-1:0] elapsed_r, elapsed_nxt;
  logic                 res_valid;
  ev_kind_t             res_kind;

  assign conn_dec = conn_r - CONN_W'(1);

  // Status update for the pending request
  always_comb begin
    conn_nxt    = conn_r;
    play_nxt    = play_r;
    pair_nxt    = pair_r;
    elapsed_nxt = elapsed_r;
    res_valid   = 1'b0;
    res_kind    = evt.kind;
    unique case (item.opcode)
      OP_BYTE: begin
        if (evt.done) begin
          res_valid = 1'b1;
          unique case (evt.kind)
            EV_CONN: begin
              if (conn_r != CONN_MAX) conn_nxt = conn_r + CONN_W'(1);
              pair_nxt = 1'b1;
            end
            EV_DISC: begin
              // a count of one never survives a disconnect
              if (conn_r != '0) conn_nxt = (conn_dec == CONN_W'(1)) ? '0 : conn_dec;
            end
            EV_PLAY: play_nxt = 1'b1;
            EV_STOP: play_nxt = 1'b0;
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        if (elapsed_r != ELAPSED_MAX) elapsed_nxt = elapsed_r + TIMEOUT_W'(1);
        if (!pair_r && (elapsed_nxt > timeout_r)) begin
          pair_nxt  = 1'b1;
          res_valid = 1'b1;
          res_kind  = EV_PAIR;
        end
      end
      OP_RESTART: begin
        conn_nxt    = '0;
        play_nxt    = 1'b0;
        pair_nxt    = 1'b0;
        elapsed_nxt = '0;
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  assign res.valid = item_valid && res_valid;
  assign res.kind  = res_kind;
  assign res.ok    = (res_kind == EV_ACK);
  assign res.conn  = conn_nxt;
  assign res.play  = play_nxt;
  assign res.pair  = pair_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      timeout_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r    <= '0;
      play_r    <= 1'b0;
      pair_r    <= 1'b1;
      elapsed_r <= '0;
    end else if (step) begin
      conn_r    <= conn_nxt;
      play_r    <= play_nxt;
      pair_r    <= pair_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  `MRLT_ASSERT_NXT(a_pair_after_req, step && res.valid && res.kind == EV_PAIR, pair_r)
  `MRLT_ASSERT_NXT(a_disc_not_one, step && res.valid && res.kind == EV_DISC,
                   conn_r != CONN_W'(1))
  `MRLT_ASSERT_NXT(a_restart_clear, step && item.opcode == OP_RESTART,
                   conn_r == '0 && !pair_r && !play_r && elapsed_r == '0)
  `MRLT_ASSERT_IMP(a_ok_only_ack, res.valid && res.ok, res.kind == EV_ACK)

endmodule

/* rtl/module_response_line_tracker_core.sv */
// A request is taken into the input register and its result is registered for the outputs.
// Throughput: one request per cycle; the input stalls only while a result waits
// and the request held in the input register also produces one.
// Reset: rst_n is synchronous, active low; clears the line state, counters and
// flags (pairing flag set) and loads the timeout with 30000 ms.
module module_response_line_tracker_core
  import mrlt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mrlt_in_if.sink     in_if,
  mrlt_out_if.source  out_if,
  mrlt_cfg_if.sink    cfg_if
);

  logic      s1_valid_r, s1_valid_nxt;
  item_t     s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  result_t   out_r;
  line_evt_t evt;
  result_t   res;
  logic      in_take, go;

  // Request advances when its result, if any, has room
  assign go           = s1_valid_r && (!res.valid || !out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || go;
  assign in_take      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  mrlt_line u_line (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .step       (go),
    .evt        (evt)
  );

  mrlt_stat u_stat (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .evt        (evt),
    .step       (go),
    .cfg_we     (cfg_if.valid),
    .cfg_data   (cfg_if.autopair_timeout_ms),
    .res        (res)
  );

  // Input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.opcode   <= op_t'(in_if.opcode);
      s1_item_r.rx_byte  <= in_if.rx_byte;
      s1_item_r.stop_bit <= in_if.stop_bit;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go && res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.valid) begin
      out_r <= res;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.event_kind       = out_r.kind;
  assign out_if.ok_seen          = out_r.ok;
  assign out_if.connection_count = out_r.conn;
  assign out_if.playback_active  = out_r.play;
  assign out_if.pairing_active   = out_r.pair;

endmodule

/* bench/mrlt_event_checker.sv */
// Watches the request, event and timeout channels of the line tracker, keeps its own
// copy of the tracker state and checks every event against the oldest prediction.
module mrlt_event_checker
  import mrlt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mrlt_in_if         in_ch,
  mrlt_out_if        out_ch,
  mrlt_cfg_if        cfg_ch,
  output int         n_errors,
  output int         n_waiting,
  output int         n_events,
  output logic [6:0] kinds_hit
);

  typedef struct packed {
    ev_kind_t          kind;
    logic              ok;
    logic [CONN_W-1:0] conn;
    logic              play;
    logic              pair;
  } status_evt_t;

  // Predicted tracker state
  logic [LEN_W-1:0]     ln_len;
  logic [CHAR_W-1:0]    ch0;
  logic [CHAR_W-1:0]    ch1;
  logic                 ln_cr;
  logic                 ln_wait;
  logic [CONN_W-1:0]    conns;
  logic                 play_on;
  logic                 pair_on;
  logic [TIMEOUT_W-1:0] ms_since;
  logic [TIMEOUT_W-1:0] pair_timeout;

  status_evt_t pending_evts[$];
  int          err_cnt = 0;
  int          evt_cnt = 0;
  logic [6:0]  seen_kinds = '0;

  initial begin
    n_errors  = 0;
    n_waiting = 0;
    n_events  = 0;
    kinds_hit = '0;
  end

  function automatic bit is_code(input logic [CHAR_W-1:0] a, input logic [CHAR_W-1:0] b);
    return ln_len == CODE_LEN && ch0 == a && ch1 == b;
  endfunction

  function automatic status_evt_t snapshot(input ev_kind_t k, input logic ack);
    status_evt_t ev;
    ev.kind = k;
    ev.ok   = ack;
    ev.conn = conns;
    ev.play = play_on;
    ev.pair = pair_on;
    return ev;
  endfunction

  // Applies one request to the predicted state; returns 1 when it raises an event
  function automatic bit advance_tracker(input op_t op, input logic [CHAR_W-1:0] b,
                                         input logic stp, output status_evt_t ev);
    ev_kind_t k;
    logic     ack;
    ev  = '0;
    ack = 1'b0;
    case (op)
      OP_BYTE: begin
        if (!stp) return 0;
        // line must open with an upper case letter
        if ((ln_wait || ln_len == 0) && (b < CH_A || b > CH_Z)) return 0;
        if (ln_len >= LEN_LIMIT) return 0;
        ln_wait = 1'b0;
        if (b == CH_LF && ln_cr && ln_len != 0) begin
          if (is_code(CH_O, CH_N) || is_code(CH_O, CH_K)) begin
            k   = EV_ACK;
            ack = 1'b1;
          end else if (is_code(CH_I, CH_I)) begin
            if (conns != CONN_MAX) conns++;
            pair_on = 1'b1;
            k = EV_CONN;
          end else if (is_code(CH_I, CH_A)) begin
            // a count that lands on one collapses to zero
            if (conns != 0) begin
              conns--;
              if (conns == 1) conns = 0;
            end
            k = EV_DISC;
          end else if (is_code(CH_M, CH_B)) begin
            play_on = 1'b1;
            k = EV_PLAY;
          end else if (is_code(CH_M, CH_A)) begin
            play_on = 1'b0;
            k = EV_STOP;
          end else begin
            k = EV_UNKNOWN;
          end
          ln_len  = '0;
          ln_cr   = 1'b0;
          ln_wait = 1'b1;
          ev = snapshot(k, ack);
          return 1;
        end
        if (ln_len == 0) ch0 = b;
        else if (ln_len == 1) ch1 = b;
        ln_cr  = (b == CH_CR);
        ln_len = ln_len + 1'b1;
        return 0;
      end
      OP_TICK: begin
        if (ms_since != ELAPSED_MAX) ms_since++;
        if (!pair_on && ms_since > pair_timeout) begin
          pair_on = 1'b1;
          ev = snapshot(EV_PAIR, 1'b0);
          return 1;
        end
        return 0;
      end
      OP_RESTART: begin
        // line in progress survives a restart
        conns    = '0;
        play_on  = 1'b0;
        pair_on  = 1'b0;
        ms_since = '0;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  task automatic report(input string what, input int want, input int got);
    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    status_evt_t want;
    status_evt_t fresh;
    if (!rst_n) begin
      ln_len       = '0;
      ch0          = '0;
      ch1          = '0;
      ln_cr        = 1'b0;
      ln_wait      = 1'b0;
      conns        = '0;
      play_on      = 1'b0;
      pair_on      = 1'b1;
      ms_since     = '0;
      pair_timeout = TIMEOUT_RST;
      pending_evts.delete();
    end else begin
      // events first: a request taken at this edge cannot be answered yet
      if (out_ch.valid && out_ch.ready) begin
        evt_cnt++;
        if (out_ch.event_kind <= EV_PAIR) seen_kinds[out_ch.event_kind] = 1'b1;
        if (pending_evts.size() == 0) begin
          $display("%0t: expected no event, got event_kind %0d", $time, out_ch.event_kind);
          err_cnt++;
        end else begin
          want = pending_evts.pop_front();
          if (out_ch.event_kind !== want.kind)
            report("event_kind", want.kind, out_ch.event_kind);
          if (out_ch.ok_seen !== want.ok)
            report("ok_seen", want.ok, out_ch.ok_seen);
          if (out_ch.connection_count !== want.conn)
            report("connection_count", want.conn, out_ch.connection_count);
          if (out_ch.playback_active !== want.play)
            report("playback_active", want.play, out_ch.playback_active);
          if (out_ch.pairing_active !== want.pair)
            report("pairing_active", want.pair, out_ch.pairing_active);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) pair_timeout = cfg_ch.autopair_timeout_ms;
      if (in_ch.valid && in_ch.ready) begin
        if (advance_tracker(op_t'(in_ch.opcode), in_ch.rx_byte, in_ch.stop_bit, fresh))
          pending_evts.push_back(fresh);
      end
    end
    n_errors  <= err_cnt;
    n_waiting <= pending_evts.size();
    n_events  <= evt_cnt;
    kinds_hit <= seen_kinds;
  end

endmodule

/* bench/module_response_line_tracker_core_tb.sv */
module module_response_line_tracker_core_tb;
  import mrlt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 6;
  localparam int HOLD_LEN    = 120;

  logic clk = 1'b0;
  logic rst_n;

  mrlt_in_if  in_ch ();
  mrlt_out_if out_ch ();
  mrlt_cfg_if cfg_ch ();

  int         n_errors;
  int         n_waiting;
  int         n_events;
  logic [6:0] kinds_hit;

  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned n_reqs = 0;
  // worst-case bytes held in the open line, kept below the line limit
  int unsigned line_fill = 0;
  logic [CHAR_W-1:0] line_txt[$];

  always #4 clk = ~clk;

  module_response_line_tracker_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  mrlt_event_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .n_errors  (n_errors),
    .n_waiting (n_waiting),
    .n_events  (n_events),
    .kinds_hit (kinds_hit)
  );

  // Event side back-pressure, with long hold-offs on request
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Run-away guard
  initial begin
    int unsigned n_cyc;
    n_cyc = 0;
    while (n_cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      n_cyc++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_req(input op_t op, input logic [CHAR_W-1:0] b, input logic stp);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.rx_byte  <= b;
    in_ch.stop_bit <= stp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_reqs++;
  endtask

  task automatic send_byte(input logic [CHAR_W-1:0] b, input logic stp);
    send_req(OP_BYTE, b, stp);
    if (stp) line_fill++;
  endtask

  // CR LF ends the open line while it still has room for both bytes; otherwise it is dropped
  task automatic close_line();
    send_byte(CH_CR, 1'b1);
    send_byte(CH_LF, 1'b1);
    line_fill = 0;
  endtask

  task automatic make_room(input int unsigned n);
    if (line_fill + n + 2 > LINE_MAX - 1) close_line();
  endtask

  // Sends line_txt followed by CR LF, with the odd bad-stop byte mixed in
  task automatic send_line();
    make_room(line_txt.size());
    foreach (line_txt[i]) begin
      if ($urandom_range(15) == 0) send_byte(8'($urandom), 1'b0);
      send_byte(line_txt[i], 1'b1);
    end
    close_line();
  endtask

  task automatic send_code(input logic [CHAR_W-1:0] a, input logic [CHAR_W-1:0] b);
    line_txt.delete();
    line_txt.push_back(a);
    line_txt.push_back(b);
    send_line();
  endtask

  task automatic write_timeout(input logic [TIMEOUT_W-1:0] ms);
    cfg_ch.valid               <= 1'b1;
    cfg_ch.autopair_timeout_ms <= ms;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Waits until every predicted event has come out and the pipeline is empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly well-formed lines with random content, plus ticks, restarts and noise
  task automatic run_mix(input int unsigned n);
    int unsigned stop_at;
    stop_at = n_reqs + n;
    while (n_reqs < stop_at) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          line_txt.delete();
          case ($urandom_range(11))
            0: begin line_txt.push_back(CH_O); line_txt.push_back(CH_K); end
            1: begin line_txt.push_back(CH_O); line_txt.push_back(CH_N); end
            2, 3: begin line_txt.push_back(CH_I); line_txt.push_back(CH_I); end
            4: begin line_txt.push_back(CH_I); line_txt.push_back(CH_A); end
            5: begin line_txt.push_back(CH_M); line_txt.push_back(CH_B); end
            6: begin line_txt.push_back(CH_M); line_txt.push_back(CH_A); end
            7: begin // near miss, often with a zero byte
              line_txt.push_back(CH_O);
              line_txt.push_back($urandom_range(1) ? 8'h00 : 8'($urandom));
            end
            8: begin // code with a trailing byte
              line_txt.push_back(CH_I);
              line_txt.push_back(CH_I);
              line_txt.push_back(8'($urandom));
            end
            9: line_txt.push_back(8'($urandom_range(CH_Z, CH_A)));
            default: begin
              line_txt.push_back(8'($urandom_range(CH_Z, CH_A)));
              repeat ($urandom_range(10)) line_txt.push_back(8'($urandom));
            end
          endcase
          send_line();
        end
        11, 12, 13: repeat ($urandom_range(6, 1)) send_req(OP_TICK, 8'($urandom), 1'($urandom));
        14: send_req(OP_RESTART, 8'($urandom), 1'($urandom));
        15: send_req(OP_NONE, 8'($urandom), 1'($urandom));
        default: begin
          make_room(7);
          case ($urandom_range(3))
            0: send_byte(8'($urandom), 1'($urandom));
            1: begin // fragment left open
              send_byte(8'($urandom_range(CH_Z, CH_A)), 1'b1);
              repeat ($urandom_range(5)) send_byte(8'($urandom), 1'($urandom));
            end
            2: begin
              send_byte(CH_CR, 1'b1);
              send_byte(8'($urandom), 1'b1);
            end
            default: send_byte(CH_LF, 1'b1);
          endcase
        end
      endcase
    end
  endtask

  initial begin
    logic [CHAR_W-1:0] b;
    int                pct_snd[4];
    int                pct_rcv[4];
    pct_snd = '{0, 46, 0, 37};
    pct_rcv = '{0, 0, 46, 37};

    rst_n                      <= 1'b0;
    in_ch.valid                <= 1'b0;
    in_ch.opcode               <= OP_BYTE;
    in_ch.rx_byte              <= '0;
    in_ch.stop_bit             <= 1'b0;
    cfg_ch.valid               <= 1'b0;
    cfg_ch.autopair_timeout_ms <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: drops, every line code except ON, restart and an immediate pairing request
    write_timeout('0);
    send_req(OP_NONE, 8'hFF, 1'b1);
    send_req(OP_TICK, 8'h00, 1'b0);
    send_byte(CH_O, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    line_fill = 0;
    send_code(CH_O, CH_K);
    send_code(CH_I, CH_I);
    send_code(CH_M, CH_B);
    send_code(CH_I, CH_A);
    send_req(OP_RESTART, 8'h00, 1'b0);
    send_req(OP_TICK, 8'hFF, 1'b1);
    send_code(CH_I, CH_A);
    send_code(CH_M, CH_A);
    settle();

    // Random traffic under each handshake mix, timeout varied per phase
    for (int p = 0; p < 4; p++) begin
      snd_idle_pct  = pct_snd[p];
      rcv_stall_pct <= pct_rcv[p];
      case (p)
        0: write_timeout(TIMEOUT_W'(600000));
        2: write_timeout('0);
        default: write_timeout(TIMEOUT_W'($urandom_range(15, 1)));
      endcase
      run_mix(75);
      settle();
    end

    // Long event hold-off while connects pile up behind it
    snd_idle_pct  = 0;
    rcv_stall_pct <= 0;
    write_timeout(TIMEOUT_RST);
    hold_reqs <= hold_reqs + 1;
    repeat (20) send_code(CH_I, CH_I);
    repeat (3) send_code(CH_I, CH_A);
    settle();

    // Overflowing line: everything after the limit is lost, ticks still work
    snd_idle_pct  = 37;
    rcv_stall_pct <= 37;
    write_timeout(TIMEOUT_W'($urandom_range(4, 1)));
    send_byte(8'($urandom_range(CH_Z, CH_A)), 1'b1);
    repeat (LINE_MAX + 4) begin
      b = 8'($urandom);
      if (b == CH_LF) b = 8'h00;
      send_byte(b, 1'b1);
    end
    close_line();
    send_code(CH_O, CH_K);
    send_req(OP_RESTART, 8'($urandom), 1'b1);
    send_code(CH_I, CH_I);
    repeat (8) send_req(OP_TICK, 8'($urandom), 1'($urandom));
    settle();

    $display("Covered %0d requests: code lines, noise, bad stop bits, ticks, restarts,",
             n_reqs);
    $display("a long event hold-off and line overflow; %0d events checked, kinds seen %b",
             n_events, kinds_hit);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/mrlt_pkg.sv
rtl/mrlt_chan_if.sv
rtl/mrlt_line.sv
rtl/mrlt_stat.sv
rtl/module_response_line_tracker_core.sv
bench/mrlt_event_checker.sv
bench/module_response_line_tracker_core_tb.sv
